// ===== rtl/core/tsrm_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrm_pkg
// Shared types and defaults for the two-way sorted run merger.
// ----------------------------------------------------------------------------
package tsrm_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int KEY_BYTES_DEF    = 8;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int KEY_PORT_W = 64;
  localparam int PAY_PORT_W = 32;

  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_t;

  typedef struct packed {
    logic accept;
    logic pop;
    logic marker;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic pick_valid;
    logic marker_due;
  } status_t;

endpackage

// ===== rtl/core/tsrm_queue.sv =====
// ----------------------------------------------------------------------------
// tsrm_queue
// Circular buffer for one run, with head word shown ahead of pop.
// ----------------------------------------------------------------------------
module tsrm_queue #(
  parameter int DEPTH = tsrm_pkg::QUEUE_DEPTH_DEF,
  parameter int DW    = 96
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] head_data,
  output logic          empty,
  output logic          full,
  output logic          one_left
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [DW-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (push) begin
      tail_nxt = wrap_inc(tail_r);
      fill_nxt = fill_r + FILL_W'(1);
    end else if (pop) begin
      head_nxt = wrap_inc(head_r);
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= wdata;
    end
  end

  assign head_data = mem_r[head_r];
  assign empty     = (fill_r == '0);
  assign full      = (fill_r == FILL_W'(DEPTH));
  assign one_left  = (fill_r == FILL_W'(1));

endmodule

// ===== rtl/core/tsrm_dp.sv =====
// ----------------------------------------------------------------------------
// tsrm_dp
// Merge datapath: two run queues, end flags, head compare, result register.
// ----------------------------------------------------------------------------
module tsrm_dp #(
  parameter int QUEUE_DEPTH  = tsrm_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_BYTES    = tsrm_pkg::KEY_BYTES_DEF,
  parameter int PAYLOAD_BITS = tsrm_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tsrm_pkg::cmd_t                  cmd,
  output tsrm_pkg::status_t               status,
  input  logic                            in_side,
  input  logic                            in_has_entry,
  input  logic [tsrm_pkg::KEY_PORT_W-1:0] in_key,
  input  logic [tsrm_pkg::PAY_PORT_W-1:0] in_payload,
  input  logic                            in_run_end,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [tsrm_pkg::KEY_PORT_W-1:0] out_key,
  output logic [tsrm_pkg::PAY_PORT_W-1:0] out_payload,
  output logic                            out_from_side,
  output logic                            out_stream_last,
  output logic                            out_overflow
);

  localparam int KW = 8 * KEY_BYTES;
  localparam int PW = (PAYLOAD_BITS < tsrm_pkg::PAY_PORT_W) ? PAYLOAD_BITS
                                                            : tsrm_pkg::PAY_PORT_W;
  localparam int DW = KW + PW;

  logic          l_end_r, l_end_nxt, r_end_r, r_end_nxt;
  logic [DW-1:0] wdata, l_head, r_head, sel_head;
  logic          l_empty, l_full, l_one, r_empty, r_full, r_one;
  logic          l_push, r_push, l_pop, r_pop;
  logic          side_ended, side_full, pushing, ovf;
  logic          l_ne, r_ne, pick_valid, pick_side, last;
  logic [KW-1:0] lk, rk;

  logic          out_valid_r, out_valid_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [PW-1:0] pay_r, pay_nxt;
  logic          from_r, from_nxt, last_r, last_nxt, ovf_r, ovf_nxt;

  assign wdata = {in_payload[PW-1:0], in_key[KW-1:0]};

  assign side_ended = in_side ? r_end_r : l_end_r;
  assign side_full  = in_side ? r_full : l_full;
  assign pushing    = cmd.accept & ~side_ended & in_has_entry;
  assign ovf        = pushing & side_full;
  assign l_push     = pushing & ~side_full & ~in_side;
  assign r_push     = pushing & ~side_full & in_side;

  assign l_ne = ~l_empty;
  assign r_ne = ~r_empty;
  assign lk   = l_head[KW-1:0];
  assign rk   = r_head[KW-1:0];

  assign pick_valid = (l_ne & r_ne) | (l_ne & r_end_r) | (r_ne & l_end_r);
  assign pick_side  = (l_ne & r_ne) ? ~(lk < rk) : r_ne;
  assign last       = l_end_r & r_end_r &
                      (pick_side ? (r_one & l_empty) : (l_one & r_empty));
  assign sel_head   = pick_side ? r_head : l_head;

  assign l_pop = cmd.pop & ~pick_side;
  assign r_pop = cmd.pop & pick_side;

  tsrm_queue #(.DEPTH(QUEUE_DEPTH), .DW(DW)) u_left (
    .clk(clk), .rst_n(rst_n), .push(l_push), .wdata(wdata), .pop(l_pop),
    .head_data(l_head), .empty(l_empty), .full(l_full), .one_left(l_one)
  );

  tsrm_queue #(.DEPTH(QUEUE_DEPTH), .DW(DW)) u_right (
    .clk(clk), .rst_n(rst_n), .push(r_push), .wdata(wdata), .pop(r_pop),
    .head_data(r_head), .empty(r_empty), .full(r_full), .one_left(r_one)
  );

  always_comb begin
    l_end_nxt = l_end_r;
    r_end_nxt = r_end_r;
    if (cmd.accept && !side_ended && in_run_end) begin
      if (in_side) begin
        r_end_nxt = 1'b1;
      end else begin
        l_end_nxt = 1'b1;
      end
    end
    if ((cmd.pop && last) || cmd.marker) begin
      l_end_nxt = 1'b0;
      r_end_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    from_nxt      = from_r;
    last_nxt      = last_r;
    ovf_nxt       = ovf_r;
    if (ovf) begin
      out_valid_nxt = 1'b1;
      key_nxt       = '0;
      pay_nxt       = '0;
      from_nxt      = in_side;
      last_nxt      = 1'b0;
      ovf_nxt       = 1'b1;
    end else if (cmd.pop) begin
      out_valid_nxt = 1'b1;
      key_nxt       = sel_head[KW-1:0];
      pay_nxt       = sel_head[DW-1:KW];
      from_nxt      = pick_side;
      last_nxt      = last;
      ovf_nxt       = 1'b0;
    end else if (cmd.marker) begin
      out_valid_nxt = 1'b1;
      key_nxt       = '0;
      pay_nxt       = '0;
      from_nxt      = 1'b0;
      last_nxt      = 1'b1;
      ovf_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_end_r     <= 1'b0;
      r_end_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      l_end_r     <= l_end_nxt;
      r_end_r     <= r_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    pay_r  <= pay_nxt;
    from_r <= from_nxt;
    last_r <= last_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign status.out_free   = ~out_valid_r | ~out_stall;
  assign status.pick_valid = pick_valid;
  assign status.marker_due = l_end_r & r_end_r & l_empty & r_empty;

  assign out_valid       = out_valid_r;
  assign out_key         = tsrm_pkg::KEY_PORT_W'(key_r);
  assign out_payload     = tsrm_pkg::PAY_PORT_W'(pay_r);
  assign out_from_side   = from_r;
  assign out_stream_last = last_r;
  assign out_overflow    = ovf_r;

endmodule

// ===== rtl/core/tsrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsrm_ctrl
// Merge sequencer: takes a word, then drains heads one result per cycle while out_stall does not hold the result.
// ----------------------------------------------------------------------------
module tsrm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tsrm_pkg::status_t status,
  output tsrm_pkg::cmd_t    cmd
);

  tsrm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsrm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.pop    = 1'b0;
    cmd.marker = 1'b0;
    case (state_r)
      tsrm_pkg::ST_IDLE: begin
        in_stall = ~status.out_free;
        if (in_valid && status.out_free) begin
          cmd.accept = 1'b1;
          state_nxt  = tsrm_pkg::ST_MERGE;
        end
      end
      tsrm_pkg::ST_MERGE: begin
        if (!status.out_free) begin
          state_nxt = tsrm_pkg::ST_MERGE;
        end else if (status.pick_valid) begin
          cmd.pop = 1'b1;
        end else if (status.marker_due) begin
          cmd.marker = 1'b1;
          state_nxt  = tsrm_pkg::ST_IDLE;
        end else begin
          in_stall = 1'b0;
          if (in_valid) begin
            cmd.accept = 1'b1;
          end else begin
            state_nxt = tsrm_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = tsrm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/two_way_sorted_run_merger.sv =====
// ----------------------------------------------------------------------------
// two_way_sorted_run_merger
// Merges a left and a right ascending run of keys into one ascending stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): each word pushes one key and payload,
// an end mark, or both, onto the side named by in_side. Each side buffers
// up to QUEUE_DEPTH entries; a push onto a full side is dropped and
// gives one overflow result instead. Result channel (out_valid/out_stall):
// merged entries, smallest key first, right side first on equal keys;
// stream_last marks the final entry once both runs ended, or comes as a
// marker word alone. A word is taken, then each result it causes passes
// the head compare into the result register, and once nothing is left to
// pop the sequencer takes the next word. Results are registered and show
// in the cycle after the pop or the accepting cycle.
// Reset clears fill counts, pointers, end flags and the result valid
// flag; queue contents and result fields are not cleared. While
// out_stall holds a result, the merge stops and no input word is taken.
// ----------------------------------------------------------------------------
module two_way_sorted_run_merger #(
  parameter int QUEUE_DEPTH  = tsrm_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_BYTES    = tsrm_pkg::KEY_BYTES_DEF,
  parameter int PAYLOAD_BITS = tsrm_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_side,
  input  logic                            in_has_entry,
  input  logic [tsrm_pkg::KEY_PORT_W-1:0] in_key,
  input  logic [tsrm_pkg::PAY_PORT_W-1:0] in_payload,
  input  logic                            in_run_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tsrm_pkg::KEY_PORT_W-1:0] out_key,
  output logic [tsrm_pkg::PAY_PORT_W-1:0] out_payload,
  output logic                            out_from_side,
  output logic                            out_stream_last,
  output logic                            out_overflow
);

  tsrm_pkg::cmd_t    cmd;
  tsrm_pkg::status_t status;

  tsrm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .status(status), .cmd(cmd)
  );

  tsrm_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .KEY_BYTES(KEY_BYTES), .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .in_side(in_side), .in_has_entry(in_has_entry), .in_key(in_key),
    .in_payload(in_payload), .in_run_end(in_run_end),
    .out_stall(out_stall), .out_valid(out_valid), .out_key(out_key),
    .out_payload(out_payload), .out_from_side(out_from_side),
    .out_stream_last(out_stream_last), .out_overflow(out_overflow)
  );

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.pop, cmd.marker}))
    else $error("merger issued more than one command");

  a_accept_when_settled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (!status.pick_valid && !status.marker_due))
    else $error("word taken while merge work was pending");

  a_no_accept_over_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !(out_valid && out_stall))
    else $error("word taken while result register is held");

  a_last_not_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> !out_stream_last)
    else $error("overflow report flagged as stream end");

endmodule
